>>> rtl/core/csr_pkg.sv
// Shared types and constants for the current soft-start ramp.
package csr_pkg;

    localparam int CUR_W   = 24;
    localparam int SAMP_W  = 12;
    localparam int PROD_W  = SAMP_W + CUR_W;
    localparam int DRV_W   = 14;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W   = 24;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 40;
    localparam int DIV_STEPS = 4;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        PH_DEC  = 2'd0,
        PH_INC  = 2'd1,
        PH_OFF  = 2'd2,
        PH_HOLD = 2'd3
    } t_phase;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RAMP_ENABLE = 2'd0,
        CFG_RAMP_STEP   = 2'd1,
        CFG_FULL_SCALE  = 2'd2,
        CFG_OUTPUT_GAIN = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_RAMP,
        ST_DRV,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic capture;
        logic mult;
        logic div_step;
        logic ramp;
        logic drive;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic div_last;
    } t_dp_stat;

endpackage

>>> rtl/core/csr_ctrl.sv
// Sequencing state machine and output valid flag for the current ramp.
module csr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_valid,
    output logic              o_s_ready,
    input  logic              i_m_ready,
    output logic              o_m_valid,
    input  csr_pkg::t_dp_stat i_stat,
    output csr_pkg::t_dp_cmd  o_cmd
);
    import csr_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_m_ready;
        o_cmd       = '0;
        o_s_ready   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mult = 1'b1;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = ST_RAMP;
                end
            end
            ST_RAMP: begin
                o_cmd.ramp = 1'b1;
                n_state = ST_DRV;
            end
            ST_DRV: begin
                o_cmd.drive = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_out_valid || i_m_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_m_valid = r_out_valid;

endmodule

>>> rtl/core/csr_dp.sv
// Datapath: configuration, target divider, ramp update and drive product.
module csr_dp #(
    parameter int ADC_MAX     = 4095,
    parameter int DRIVE_LIMIT = 10000
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [csr_pkg::CFG_IDX_W-1:0]        i_cfg_addr,
    input  logic [csr_pkg::CFG_W-1:0]            i_cfg_wdata,
    input  logic [csr_pkg::S_DATA_W-1:0]         i_in_data,
    output logic [csr_pkg::M_DATA_W-1:0]         o_out_data,
    input  csr_pkg::t_dp_cmd                     i_cmd,
    output csr_pkg::t_dp_stat                    o_stat
);
    import csr_pkg::*;

    localparam int DW = $clog2(ADC_MAX + 1);
    localparam int HALF = PROD_W / 2;
    // The reciprocal of any ADC_MAX of 255 or more fits in this width.
    localparam int RCP_W = PROD_W - 7;
    localparam int XW = CUR_W + 16;
    localparam logic [DW-1:0] DIVISOR = DW'(ADC_MAX);
    localparam logic [RCP_W-1:0] RECIP = RCP_W'((64'd1 << PROD_W) / 64'(ADC_MAX));
    localparam logic [XW-1:0] SAT_LIM = XW'(ADC_MAX) << CUR_W;
    localparam logic [15:0] LIMIT = 16'(DRIVE_LIMIT);

    logic              r_enable;
    logic [CUR_W-1:0]  r_step, r_fsc, r_gain;
    logic [SAMP_W-1:0] r_sample;
    logic              r_event, r_level;
    logic [PROD_W-1:0] r_div;
    logic [HALF+RCP_W-1:0] r_plo, r_phi;
    logic [RCP_W-1:0]  r_qest;
    logic [XW-1:0]     r_rem;
    logic [CUR_W-1:0]  r_target;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [CUR_W-1:0]  r_current, n_current;
    t_phase            r_phase, n_phase;
    logic [2*CUR_W-1:0] r_dprod;
    logic [M_DATA_W-1:0] r_out;

    logic [PROD_W+RCP_W-1:0] rcp_sum;
    logic [CUR_W+DW-1:0] qd;
    logic              sat, fix;
    logic [CUR_W-1:0]  target, cur0;
    t_phase            ph0;
    logic [CUR_W:0]    sum;
    logic [15:0]       drv_hi, drv_cap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b1;
            r_step   <= 24'd32768;
            r_fsc    <= 24'd2949120;
            r_gain   <= 24'd14563556;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_RAMP_ENABLE: r_enable <= i_cfg_wdata[0];
                CFG_RAMP_STEP:   r_step   <= i_cfg_wdata;
                CFG_FULL_SCALE:  r_fsc    <= i_cfg_wdata;
                CFG_OUTPUT_GAIN: r_gain   <= i_cfg_wdata;
            endcase
        end
    end

    // The reciprocal estimate is at most one below the true quotient.
    assign rcp_sum = {r_phi, {HALF{1'b0}}} + (PROD_W+RCP_W)'(r_plo);
    assign qd      = (CUR_W+DW)'(r_qest[CUR_W-1:0]) * (CUR_W+DW)'(DIVISOR);
    assign sat     = XW'(r_div) >= SAT_LIM;
    assign fix     = r_rem >= XW'(DIVISOR);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_sample <= i_in_data[SAMP_W-1:0];
            r_event  <= i_in_data[SAMP_W];
            r_level  <= i_in_data[SAMP_W+1];
        end
        if (i_cmd.mult) begin
            r_div <= PROD_W'(r_sample) * PROD_W'(r_fsc);
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_plo    <= (HALF+RCP_W)'(r_div[HALF-1:0]) * (HALF+RCP_W)'(RECIP);
            r_phi    <= (HALF+RCP_W)'(r_div[PROD_W-1:HALF]) * (HALF+RCP_W)'(RECIP);
            r_qest   <= rcp_sum[PROD_W+RCP_W-1:PROD_W];
            r_rem    <= XW'(r_div) - XW'(qd);
            r_target <= sat ? '1 : r_qest[CUR_W-1:0] + CUR_W'(fix);
            r_cnt    <= r_cnt + 1'b1;
        end
        if (i_cmd.drive) begin
            r_dprod <= (2*CUR_W)'(r_current) * (2*CUR_W)'(r_gain);
        end
        if (i_cmd.out_load) begin
            r_out <= {r_current, r_phase, drv_cap[DRV_W-1:0]};
        end
    end

    assign o_stat.div_last = (r_cnt == DIV_CNT_W'(DIV_STEPS - 1));

    assign target = r_target;

    always_comb begin
        cur0      = r_event ? '0 : r_current;
        ph0       = r_event ? PH_OFF : r_phase;
        n_current = cur0;
        n_phase   = ph0;
        sum       = {1'b0, cur0} + {1'b0, r_step};
        if (r_enable) begin
            unique case (ph0)
                PH_OFF: begin
                    n_current = '0;
                    if (!r_level && target != '0) begin
                        n_phase = PH_INC;
                    end
                end
                PH_INC: begin
                    if (cur0 < target) begin
                        n_current = sum[CUR_W] ? '1 : sum[CUR_W-1:0];
                    end else begin
                        n_phase   = PH_HOLD;
                        n_current = target;
                    end
                end
                PH_DEC: begin
                    if (cur0 > target) begin
                        n_current = (cur0 > r_step) ? cur0 - r_step : '0;
                    end else begin
                        n_phase   = PH_HOLD;
                        n_current = target;
                    end
                end
                PH_HOLD: begin
                    if (target > cur0) begin
                        n_phase = PH_INC;
                    end else if (cur0 > target) begin
                        n_phase = PH_DEC;
                    end
                    if (target == '0) begin
                        n_phase = PH_OFF;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_current <= '0;
            r_phase   <= PH_DEC;
        end else if (i_cmd.ramp) begin
            r_current <= n_current;
            r_phase   <= n_phase;
        end
    end

    assign drv_hi  = r_dprod[2*CUR_W-1:32];
    assign drv_cap = (drv_hi > LIMIT) ? LIMIT : drv_hi;

    assign o_out_data = r_out;

endmodule

>>> rtl/core/current_soft_start_ramp_top.sv
// Top level of the current soft-start ramp: controller plus datapath.
// Each accepted item is one control tick and yields one result item. The result is
// computed in this order: the sample-times-full-scale product, the division by ADC_MAX
// (reciprocal multiplication in two halves, the sum, the remainder and the final
// correction with saturation), the ramp update, the drive product and the load of the
// output register. Only one tick is in flight. The next item is accepted once the
// result is loaded, even while that result still waits in the output register; a
// result that is still waiting when the next one is ready stalls the controller.
module current_soft_start_ramp_top #(
    parameter int ADC_MAX     = 4095,
    parameter int DRIVE_LIMIT = 10000
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [csr_pkg::CFG_IDX_W-1:0]      i_cfg_addr,
    input  logic [csr_pkg::CFG_W-1:0]          i_cfg_wdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // request_sample[11:0], fault_event[12], fault_level[13], zero[15:14]
    input  logic [csr_pkg::S_DATA_W-1:0]       s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // drive_count[13:0], ramp_phase[15:14], present_current[39:16]
    output logic [csr_pkg::M_DATA_W-1:0]       m_axis_tdata
);
    import csr_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    csr_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_m_ready (m_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    csr_dp #(
        .ADC_MAX     (ADC_MAX),
        .DRIVE_LIMIT (DRIVE_LIMIT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (s_axis_tdata),
        .o_out_data  (m_axis_tdata),
        .i_cmd       (cmd),
        .o_stat      (stat)
    );

endmodule

>>> rtl/core/csr_checker.sv
// Port-level checker for the current soft-start ramp and its bind.
module csr_checker #(
    parameter int DRIVE_LIMIT = 10000
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_s_valid,
    input logic                         i_s_ready,
    input logic                         i_m_valid,
    input logic                         i_m_ready,
    input logic [csr_pkg::M_DATA_W-1:0] i_m_data
);
    import csr_pkg::*;

    localparam logic [DRV_W-1:0] LIMIT = DRV_W'(DRIVE_LIMIT);

    a_reset_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_valid)
        else $error("result valid not cleared by reset");

    a_one_item_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_valid && i_s_ready) |=> !i_s_ready)
        else $error("input accepted while an item is in progress");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_valid && !i_m_ready) |=> i_m_valid)
        else $error("result dropped before it was taken");

    a_drive_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_valid && DRIVE_LIMIT <= 16383) |-> (i_m_data[DRV_W-1:0] <= LIMIT))
        else $error("drive count above limit");

endmodule

bind current_soft_start_ramp_top csr_checker #(
    .DRIVE_LIMIT (DRIVE_LIMIT)
) u_csr_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_s_valid (s_axis_tvalid),
    .i_s_ready (s_axis_tready),
    .i_m_valid (m_axis_tvalid),
    .i_m_ready (m_axis_tready),
    .i_m_data  (m_axis_tdata)
);

>>> tb/ramp_checker.sv
// Checker for the current soft-start ramp: predicts each tick's result and compares it.
module ramp_checker #(
    parameter int ADC_MAX     = 4095,
    parameter int DRIVE_LIMIT = 10000
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [csr_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [csr_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic                          i_tick_valid,
    input  logic                          i_tick_ready,
    // request_sample[11:0], fault_event[12], fault_level[13], zero[15:14]
    input  logic [csr_pkg::S_DATA_W-1:0]  i_tick_data,
    input  logic                          i_res_valid,
    input  logic                          i_res_ready,
    // drive_count[13:0], ramp_phase[15:14], present_current[39:16]
    input  logic [csr_pkg::M_DATA_W-1:0]  i_res_data,
    output int                            o_errors,
    output int                            o_pending,
    output int                            o_checked
);
    import csr_pkg::*;

    typedef struct {
        logic [DRV_W-1:0] drive;
        t_phase           phase;
        logic [CUR_W-1:0] amps;
    } t_tick_result;

    t_tick_result     expected_results[$];

    logic             ramp_on;
    logic [CUR_W-1:0] slew_step;
    logic [CUR_W-1:0] full_scale;
    logic [CUR_W-1:0] drive_gain;
    logic [CUR_W-1:0] amps_now;
    t_phase           phase_now;

    task automatic report(input string what, input logic [CUR_W-1:0] want,
                          input logic [CUR_W-1:0] got);
        o_errors++;
        if (o_errors <= 30)
            $display("MISMATCH %s: expected 0x%0h, got 0x%0h at result %0d",
                     what, want, got, o_checked);
    endtask

    task automatic run_tick(input logic [SAMP_W-1:0] sample, input logic fault_evt,
                            input logic fault_lvl, output t_tick_result res);
        logic [PROD_W-1:0] prod;
        logic [PROD_W-1:0] quot;
        logic [CUR_W-1:0]  target;
        logic [CUR_W:0]    sum;
        logic [2*CUR_W-1:0] drive_prod;
        logic [CUR_W-1:0]  drive_int;
        prod = PROD_W'(sample) * PROD_W'(full_scale);
        quot = prod / PROD_W'(ADC_MAX);
        target = (quot > PROD_W'(24'hFFFFFF)) ? 24'hFFFFFF : quot[CUR_W-1:0];
        if (fault_evt) begin
            amps_now = '0;
            phase_now = PH_OFF;
        end
        if (ramp_on) begin
            case (phase_now)
                PH_OFF: begin
                    amps_now = '0;
                    if (!fault_lvl && target != 0)
                        phase_now = PH_INC;
                end
                PH_INC: begin
                    if (amps_now < target) begin
                        sum = {1'b0, amps_now} + {1'b0, slew_step};
                        amps_now = sum[CUR_W] ? 24'hFFFFFF : sum[CUR_W-1:0];
                    end else begin
                        phase_now = PH_HOLD;
                        amps_now = target;
                    end
                end
                PH_DEC: begin
                    if (amps_now > target) begin
                        amps_now = (amps_now > slew_step) ? amps_now - slew_step : '0;
                    end else begin
                        phase_now = PH_HOLD;
                        amps_now = target;
                    end
                end
                default: begin
                    if (target > amps_now)
                        phase_now = PH_INC;
                    else if (amps_now > target)
                        phase_now = PH_DEC;
                    if (target == 0)
                        phase_now = PH_OFF;
                end
            endcase
        end
        drive_prod = (2*CUR_W)'(amps_now) * (2*CUR_W)'(drive_gain);
        drive_int = {8'd0, drive_prod[2*CUR_W-1:32]};
        if (drive_int > CUR_W'(DRIVE_LIMIT))
            drive_int = CUR_W'(DRIVE_LIMIT);
        res.drive = drive_int[DRV_W-1:0];
        res.phase = phase_now;
        res.amps = amps_now;
    endtask

    always @(posedge i_clk) begin
        t_tick_result res;
        t_tick_result want;
        if (!i_rst_n) begin
            ramp_on = 1'b1;
            slew_step = 24'd32768;
            full_scale = 24'd2949120;
            drive_gain = 24'd14563556;
            amps_now = '0;
            phase_now = PH_DEC;
            expected_results.delete();
            o_errors = 0;
            o_checked = 0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_addr))
                    CFG_RAMP_ENABLE: ramp_on = i_cfg_wdata[0];
                    CFG_RAMP_STEP:   slew_step = i_cfg_wdata;
                    CFG_FULL_SCALE:  full_scale = i_cfg_wdata;
                    CFG_OUTPUT_GAIN: drive_gain = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_tick_valid && i_tick_ready) begin
                run_tick(i_tick_data[11:0], i_tick_data[12], i_tick_data[13], res);
                expected_results.push_back(res);
            end
            if (i_res_valid && i_res_ready) begin
                if (expected_results.size() == 0) begin
                    report("unexpected result", '0, i_res_data[39:16]);
                end else begin
                    want = expected_results.pop_front();
                    if (i_res_data[13:0] !== want.drive)
                        report("drive_count", CUR_W'(want.drive), CUR_W'(i_res_data[13:0]));
                    if (i_res_data[15:14] !== want.phase)
                        report("ramp_phase", CUR_W'(want.phase), CUR_W'(i_res_data[15:14]));
                    if (i_res_data[39:16] !== want.amps)
                        report("present_current", want.amps, i_res_data[39:16]);
                end
                o_checked++;
            end
        end
        o_pending = expected_results.size();
    end

endmodule

>>> tb/testbench.sv
// Top of the ramp testbench: clock, reset, register settings, tick stimulus and verdict.
module testbench;
    import csr_pkg::*;

    localparam int IDLE_LIMIT  = 5000;
    localparam int END_SETTLE  = 60;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_addr = '0;
    logic [CFG_W-1:0]      i_cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_axis_tdata;

    int errors;
    int pending;
    int checked;
    int send_idle = 0;
    int recv_idle = 0;
    int ticks_sent = 0;
    int settings_used = 0;
    int quiet_cycles = 0;

    logic [SAMP_W-1:0] run_sample = '0;
    int                run_left = 0;
    logic              level_now = 1'b0;

    current_soft_start_ramp_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    ramp_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_wdata(i_cfg_wdata),
        .i_tick_valid(s_axis_tvalid), .i_tick_ready(s_axis_tready),
        .i_tick_data(s_axis_tdata),
        .i_res_valid(m_axis_tvalid), .i_res_ready(m_axis_tready),
        .i_res_data(m_axis_tdata),
        .o_errors(errors), .o_pending(pending), .o_checked(checked)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        m_axis_tready = ($urandom_range(0, 99) >= recv_idle);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= IDLE_LIMIT) begin
                $display("Watchdog expired after %0d quiet cycles", quiet_cycles);
                $display("Test completed with failures");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic send_tick(input logic [SAMP_W-1:0] sample, input logic fault_evt,
                             input logic fault_lvl);
        while ($urandom_range(0, 99) < send_idle) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {2'b00, fault_lvl, fault_evt, sample};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        ticks_sent++;
    endtask

    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (pending != 0)
            @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] value);
        i_cfg_we = 1'b1;
        i_cfg_addr = idx;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic apply_setting(input logic ramp_on, input logic [CFG_W-1:0] step,
                                 input logic [CFG_W-1:0] scale, input logic [CFG_W-1:0] gain);
        drain();
        write_reg(CFG_RAMP_ENABLE, {23'd0, ramp_on});
        write_reg(CFG_RAMP_STEP, step);
        write_reg(CFG_FULL_SCALE, scale);
        write_reg(CFG_OUTPUT_GAIN, gain);
        settings_used++;
    endtask

    // Mostly steady requests held for a run of ticks so ramps can finish, with sparse
    // faults and level bursts; a tenth of the ticks are unstructured noise.
    task automatic random_ticks(input int count);
        int                pick;
        logic              fault_evt;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 79) == 0)
                drain();
            if ($urandom_range(0, 9) == 0) begin
                send_tick(SAMP_W'($urandom), 1'($urandom), 1'($urandom));
            end else begin
                if (run_left == 0) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 15)
                        run_sample = '0;
                    else if (pick < 30)
                        run_sample = 12'hFFF;
                    else
                        run_sample = SAMP_W'($urandom);
                    run_left = $urandom_range(1, 24);
                end
                run_left--;
                if (level_now)
                    level_now = ($urandom_range(0, 4) != 0);
                else
                    level_now = ($urandom_range(0, 24) == 0);
                fault_evt = ($urandom_range(0, 29) == 0);
                send_tick(run_sample, fault_evt, level_now);
            end
        end
    endtask

    initial begin
        logic [CFG_W-1:0] scale;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_idle = 32;
        recv_idle = 69;
        write_reg(CFG_RAMP_STEP, 24'h0A0000);
        send_tick(12'd0, 1'b0, 1'b0);
        send_tick(12'd0, 1'b0, 1'b0);
        send_tick(12'hFFF, 1'b0, 1'b1);
        send_tick(12'hFFF, 1'b0, 1'b0);
        repeat (7) send_tick(12'hFFF, 1'b0, 1'b0);
        repeat (4) send_tick(12'd2048, 1'b0, 1'b0);
        repeat (4) send_tick(12'd1, 1'b0, 1'b0);
        send_tick(12'hFFF, 1'b1, 1'b0);
        send_tick(12'hFFF, 1'b0, 1'b0);
        send_tick(12'hFFF, 1'b1, 1'b1);
        send_tick(12'd0, 1'b0, 1'b0);
        send_tick(12'd1, 1'b0, 1'b0);
        drain();
        write_reg(CFG_RAMP_ENABLE, 24'd0);
        send_tick(12'hFFF, 1'b0, 1'b0);
        send_tick(12'hFFF, 1'b1, 1'b0);
        send_tick(12'hFFF, 1'b0, 1'b0);

        apply_setting(1'b1, 24'd32768, 24'd2949120, 24'd14563556);
        random_ticks(55);
        apply_setting(1'b1, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        random_ticks(55);
        apply_setting(1'b1, 24'd0, CFG_W'($urandom), CFG_W'($urandom));
        random_ticks(50);

        send_idle = 69;
        recv_idle = 32;
        apply_setting(1'b1, 24'd1, 24'd0, 24'd0);
        random_ticks(40);
        scale = CFG_W'($urandom_range(24'h100000, 24'hFFFFFF));
        apply_setting(1'b1, scale / CFG_W'($urandom_range(4, 16)), scale, CFG_W'($urandom));
        random_ticks(60);
        apply_setting(1'b0, CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
        random_ticks(20);

        send_idle = 0;
        recv_idle = 0;
        apply_setting(1'b1, CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
        random_ticks(60);
        scale = CFG_W'($urandom);
        apply_setting(1'b1, scale / CFG_W'($urandom_range(2, 10)), scale, CFG_W'($urandom));
        random_ticks(70);

        drain();
        repeat (END_SETTLE) @(negedge i_clk);
        $display("Summary: %0d ticks over %0d register settings, %0d results compared.",
                 ticks_sent, settings_used + 2, checked);
        $display("Covered fault events and levels, ramp saturation, zero steps and freezes.");
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches found", errors);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
